// ===== rtl/cbt_pkg.sv =====
// Shared types, constants and the fixed-point interpolation function for the tessellator.
`default_nettype none

package cbt_pkg;

   localparam int COORD_BITS  = 16;
   localparam int STEPS_BITS  = 6;
   localparam int T_FRAC      = 16;
   localparam int T_BITS      = T_FRAC + 1;
   localparam int MAX_STEPS   = 63;
   localparam int DIV_CNT_BITS = $clog2(T_BITS);

   localparam logic [STEPS_BITS-1:0]   STEPS_RESET = STEPS_BITS'(15);
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST    = DIV_CNT_BITS'(T_BITS - 1);
   localparam logic [T_BITS-1:0]       T_ONE       = T_BITS'(1) << T_FRAC;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [STEPS_BITS-1:0]        steps_type;
   typedef logic [T_BITS-1:0]            tparam_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic lerp1;
      logic lerp2;
      logic lerp3;
      logic advance;
   } cbt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_point;
   } cbt_status_type;

   // a + floor(((b - a) * t) / 2^T_FRAC); the result always lies between a and b.
   function automatic coord_type lerp(input coord_type a, input coord_type b,
                                      input tparam_type t);
      logic signed [COORD_BITS:0]          diff;
      logic signed [COORD_BITS+T_BITS+1:0] prod;
      logic signed [COORD_BITS:0]          sum;
      diff = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
      prod = diff * $signed({1'b0, t});
      sum  = {a[COORD_BITS-1], a} + prod[T_FRAC +: COORD_BITS+1];
      return sum[COORD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cbt_ctrl.sv =====
// Controller state machine that sequences the divide, the three interpolation levels and output.
`default_nettype none

module cbt_ctrl
   import cbt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output cbt_cmd_type         cmd,
   input  wire cbt_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_L1,
      ST_L2,
      ST_L3,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    req_ready_ff;
   logic                    rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = req_valid && req_ready_ff;
      cmd.div_step = (state_ff == ST_DIV);
      cmd.lerp1    = (state_ff == ST_L1);
      cmd.lerp2    = (state_ff == ST_L2);
      cmd.lerp3    = (state_ff == ST_L3);
      cmd.advance  = (state_ff == ST_EMIT) && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  cnt_ff       <= '0;
                  state_ff     <= ST_DIV;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + DIV_CNT_BITS'(1);
               if (cnt_ff == DIV_LAST) begin
                  state_ff <= ST_L1;
               end
            end
            ST_L1: state_ff <= ST_L2;
            ST_L2: state_ff <= ST_L3;
            ST_L3: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (status.last_point) begin
                     req_ready_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_L1;
                  end
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cbt_datapath.sv =====
// Datapath: control point storage, step divider, parameter accumulator and interpolation levels.
`default_nettype none

module cbt_datapath
   import cbt_pkg::*;
(
   input  wire logic        clock,
   input  wire cbt_cmd_type cmd,
   output cbt_status_type   status,
   input  wire steps_type   steps_cfg,
   input  wire coord_type   p0_x,
   input  wire coord_type   p0_y,
   input  wire coord_type   p1_x,
   input  wire coord_type   p1_y,
   input  wire coord_type   p2_x,
   input  wire coord_type   p2_y,
   input  wire coord_type   p3_x,
   input  wire coord_type   p3_y,
   output coord_type        out_x,
   output coord_type        out_y,
   output logic             last_point
);

   coord_type  px_ff [4];
   coord_type  py_ff [4];
   steps_type  steps_ff, steps_in;
   steps_type  j_ff;

   // Restoring divider for 2^T_FRAC / steps, one quotient bit per cycle.
   tparam_type num_ff;
   tparam_type quo_ff;
   steps_type  rem_ff;
   logic [STEPS_BITS:0] rem_shift;
   logic       qbit;
   steps_type  rem_in;

   // Parameter t kept as quotient plus running remainder.
   tparam_type t_ff, t_in;
   steps_type  racc_ff, racc_in;
   logic [STEPS_BITS:0] racc_sum;

   coord_type  abx_ff, bcx_ff, cdx_ff, aby_ff, bcy_ff, cdy_ff;
   coord_type  abcx_ff, bcdx_ff, abcy_ff, bcdy_ff;
   coord_type  out_x_ff, out_y_ff;
   logic       last_ff;

   always_comb begin
      steps_in = steps_cfg;
      if (steps_cfg == '0) begin
         steps_in = STEPS_BITS'(1);
      end else if (steps_cfg > STEPS_BITS'(MAX_STEPS)) begin
         steps_in = STEPS_BITS'(MAX_STEPS);
      end
   end

   always_comb begin
      rem_shift = {rem_ff, num_ff[T_BITS-1]};
      qbit      = (rem_shift >= {1'b0, steps_ff});
      if (qbit) begin
         rem_in = STEPS_BITS'(rem_shift - {1'b0, steps_ff});
      end else begin
         rem_in = rem_shift[STEPS_BITS-1:0];
      end
   end

   always_comb begin
      racc_sum = {1'b0, racc_ff} + {1'b0, rem_ff};
      if (racc_sum >= {1'b0, steps_ff}) begin
         racc_in = STEPS_BITS'(racc_sum - {1'b0, steps_ff});
         t_in    = t_ff + quo_ff + T_BITS'(1);
      end else begin
         racc_in = racc_sum[STEPS_BITS-1:0];
         t_in    = t_ff + quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff[0] <= p0_x;
         px_ff[1] <= p1_x;
         px_ff[2] <= p2_x;
         px_ff[3] <= p3_x;
         py_ff[0] <= p0_y;
         py_ff[1] <= p1_y;
         py_ff[2] <= p2_y;
         py_ff[3] <= p3_y;
         steps_ff <= steps_in;
         j_ff     <= '0;
         num_ff   <= T_ONE;
         quo_ff   <= '0;
         rem_ff   <= '0;
         t_ff     <= '0;
         racc_ff  <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         quo_ff <= {quo_ff[T_BITS-2:0], qbit};
         rem_ff <= rem_in;
      end
      if (cmd.lerp1) begin
         abx_ff <= lerp(px_ff[0], px_ff[1], t_ff);
         bcx_ff <= lerp(px_ff[1], px_ff[2], t_ff);
         cdx_ff <= lerp(px_ff[2], px_ff[3], t_ff);
         aby_ff <= lerp(py_ff[0], py_ff[1], t_ff);
         bcy_ff <= lerp(py_ff[1], py_ff[2], t_ff);
         cdy_ff <= lerp(py_ff[2], py_ff[3], t_ff);
      end
      if (cmd.lerp2) begin
         abcx_ff <= lerp(abx_ff, bcx_ff, t_ff);
         bcdx_ff <= lerp(bcx_ff, cdx_ff, t_ff);
         abcy_ff <= lerp(aby_ff, bcy_ff, t_ff);
         bcdy_ff <= lerp(bcy_ff, cdy_ff, t_ff);
      end
      if (cmd.lerp3) begin
         out_x_ff <= lerp(abcx_ff, bcdx_ff, t_ff);
         out_y_ff <= lerp(abcy_ff, bcdy_ff, t_ff);
         last_ff  <= (j_ff == steps_ff);
      end
      if (cmd.advance) begin
         j_ff    <= j_ff + STEPS_BITS'(1);
         t_ff    <= t_in;
         racc_ff <= racc_in;
      end
   end

   assign out_x             = out_x_ff;
   assign out_y             = out_y_ff;
   assign last_point        = last_ff;
   assign status.last_point = last_ff;

endmodule

`default_nettype wire

// ===== rtl/cubic_bezier_tessellator_top.sv =====
// Top level of the cubic Bezier tessellator: step register, controller and datapath.
`default_nettype none

// Each accepted word is one cubic Bezier segment: four signed Q2.14 control
// points. The block answers with point_steps+1 result words, one curve point
// each, for t = floor(j*65536/point_steps) with j running from 0 to
// point_steps; the word at t = 1.0 carries last_point. A point_steps of zero
// is taken as one. Every point is evaluated with de Casteljau's construction,
// six two-dimensional linear interpolations with floor rounding. One segment
// is handled at a time: after the request word is accepted, a bit-serial
// divider forms 65536/point_steps, and then each point passes through the
// three interpolation levels into the output register, where it waits until
// the word is taken before the next point starts. The point_steps register
// may be written whenever the block is idle; a write takes effect with the
// next segment.

module cubic_bezier_tessellator_top
   import cbt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      csr_write_enable,
   input  wire steps_type csr_write_data,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire coord_type req_p0_x,
   input  wire coord_type req_p0_y,
   input  wire coord_type req_p1_x,
   input  wire coord_type req_p1_y,
   input  wire coord_type req_p2_x,
   input  wire coord_type req_p2_y,
   input  wire coord_type req_p3_x,
   input  wire coord_type req_p3_y,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output coord_type      rsp_out_x,
   output coord_type      rsp_out_y,
   output logic           rsp_last_point
);

   steps_type      steps_ff;
   cbt_cmd_type    cmd;
   cbt_status_type status;

   // The step count register; the datapath samples it when a word is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= STEPS_RESET;
      end else if (csr_write_enable) begin
         steps_ff <= csr_write_data;
      end
   end

   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   cbt_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .status     (status),
      .steps_cfg  (steps_ff),
      .p0_x       (req_p0_x),
      .p0_y       (req_p0_y),
      .p1_x       (req_p1_x),
      .p1_y       (req_p1_y),
      .p2_x       (req_p2_x),
      .p2_y       (req_p2_y),
      .p3_x       (req_p3_x),
      .p3_y       (req_p3_y),
      .out_x      (rsp_out_x),
      .out_y      (rsp_out_y),
      .last_point (rsp_last_point)
   );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the cubic Bezier tessellator top level.
module testbench
   import cbt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // The run is a short directed part followed by random phases. Each phase
   // programs point_steps while the block is idle and then streams segments.
   // A driver and a monitor run as clocked processes. Every accepted request
   // word is expanded into its expected curve points right at acceptance.
   // Every result word is checked against the oldest expected point.

   localparam int GAP_MAX      = 14;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 200;

   typedef struct {
      coord_type px [4];
      coord_type py [4];
   } segment_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      end_of_curve;
   } curve_point_type;

   // Every block input has a known value from time zero.
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_write_enable = 1'b0;
   steps_type   csr_write_data   = '0;
   logic        req_valid        = 1'b0;
   logic        rsp_ready        = 1'b0;
   segment_type held_segment     = '{default: '0};

   logic      req_ready;
   logic      rsp_valid;
   coord_type rsp_out_x;
   coord_type rsp_out_y;
   logic      rsp_last_point;

   // Segments waiting to be driven, and curve points the block still owes us.
   segment_type     segments_waiting [$];
   curve_point_type points_due [$];

   // Our own copy of the step register, updated on every register write.
   steps_type steps_setting = STEPS_RESET;

   // Per-phase switches that turn off idling on one side for a whole phase.
   bit quiet_send = 1'b0;
   bit quiet_recv = 1'b0;

   int send_gap      = 0;
   int recv_gap      = 0;
   int quiet_cycles  = 0;
   int mismatch_count = 0;

   cubic_bezier_tessellator_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_p0_x         (held_segment.px[0]),
      .req_p0_y         (held_segment.py[0]),
      .req_p1_x         (held_segment.px[1]),
      .req_p1_y         (held_segment.py[1]),
      .req_p2_x         (held_segment.px[2]),
      .req_p2_y         (held_segment.py[2]),
      .req_p3_x         (held_segment.px[3]),
      .req_p3_y         (held_segment.py[3]),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_last_point   (rsp_last_point)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Number of idle cycles before the next word on one side of the block.
   function automatic int draw_gap(bit quiet);
      return quiet ? 0 : int'($urandom_range(0, GAP_MAX));
   endfunction

   // One linear interpolation step with the fractional part floored toward
   // minus infinity; the arithmetic shift of a signed product does exactly that.
   function automatic longint blend(longint a, longint b, longint t);
      return a + (((b - a) * t) >>> T_FRAC);
   endfunction

   // de Casteljau on one coordinate: three levels, six interpolations.
   function automatic coord_type bezier_coord(coord_type a, coord_type b, coord_type c,
                                              coord_type d, longint t);
      longint ab, bc, cd, abc, bcd;
      ab  = blend(a, b, t);
      bc  = blend(b, c, t);
      cd  = blend(c, d, t);
      abc = blend(ab, bc, t);
      bcd = blend(bc, cd, t);
      return coord_type'(blend(abc, bcd, t));
   endfunction

   // Expands one segment into the points the block must return, in order.
   // A step count of zero behaves as one, so the curve still gets both ends.
   function automatic void tessellate_segment(segment_type s);
      int              span;
      longint          t;
      curve_point_type pt;
      span = (steps_setting == '0) ? 1 : int'(steps_setting);
      for (int j = 0; j <= span; j++) begin
         t = (longint'(j) << T_FRAC) / span;
         pt.x = bezier_coord(s.px[0], s.px[1], s.px[2], s.px[3], t);
         pt.y = bezier_coord(s.py[0], s.py[1], s.py[2], s.py[3], t);
         pt.end_of_curve = (j == span);
         points_due.push_back(pt);
      end
   endfunction

   // Coordinates sit at the extremes or near zero now and then; most are full range.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: begin
            return coord_type'(16'sh7fff);
         end
         1: begin
            return coord_type'(16'sh8000);
         end
         2: begin
            return coord_type'($urandom_range(0, 255)) - coord_type'(128);
         end
         default: begin
            return coord_type'($urandom);
         end
      endcase
   endfunction

   function automatic segment_type random_segment();
      segment_type s;
      for (int k = 0; k < 4; k++) begin
         s.px[k] = rand_coord();
         s.py[k] = rand_coord();
      end
      return s;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Waits until no segment is queued or on the bus and no point is owed.
   // Sampling at the falling edge keeps this clear of the clocked processes.
   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (segments_waiting.size() != 0 || req_valid || points_due.size() != 0);
   endtask

   // Programs point_steps once the block has gone idle, and picks how much
   // idling each side does during the phase that follows.
   task automatic start_phase(steps_type steps, bit calm_send, bit calm_recv);
      wait_for_drain();
      quiet_send = calm_send;
      quiet_recv = calm_recv;
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= steps;
      steps_setting = steps;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Request side. A segment stays on the bus, unchanged, until it is taken.
   // The expected points are worked out at the edge where it is accepted.
   always @(posedge clock) begin
      logic keep_valid;
      keep_valid = req_valid;
      if (reset) begin
         keep_valid = 1'b0;
         send_gap = draw_gap(quiet_send);
      end else begin
         if (req_valid && req_ready) begin
            tessellate_segment(held_segment);
            keep_valid = 1'b0;
            send_gap = draw_gap(quiet_send);
         end
         if (!keep_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (segments_waiting.size() != 0) begin
               held_segment <= segments_waiting.pop_front();
               keep_valid = 1'b1;
            end
         end
      end
      req_valid <= keep_valid;
   end

   // Result side. Each word taken is compared with the oldest owed point;
   // ready may then drop for a random gap before the next word.
   always @(posedge clock) begin
      curve_point_type due;
      if (reset) begin
         recv_gap = draw_gap(quiet_recv);
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (points_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word x=%0d y=%0d last=%0b",
                                         rsp_out_x, rsp_out_y, rsp_last_point));
            end else begin
               due = points_due.pop_front();
               if (rsp_out_x !== due.x) begin
                  report_mismatch($sformatf("out_x %0d, expected %0d", rsp_out_x, due.x));
               end
               if (rsp_out_y !== due.y) begin
                  report_mismatch($sformatf("out_y %0d, expected %0d", rsp_out_y, due.y));
               end
               if (rsp_last_point !== due.end_of_curve) begin
                  report_mismatch($sformatf("last_point %0b, expected %0b",
                                            rsp_last_point, due.end_of_curve));
               end
            end
            recv_gap = draw_gap(quiet_recv);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: a long stretch with no word moving on either side means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      segment_type seg;
      steps_type   steps;
      int          phase_items;
      int          issued;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, first at the reset step count of fifteen.
      // Flat curves at zero and at both rails, then zigzags between the rails
      // that drive interpolation differences to their largest magnitude.
      seg = '{px: '{default: coord_type'(0)}, py: '{default: coord_type'(0)}};
      segments_waiting.push_back(seg);
      seg = '{px: '{default: coord_type'(16'sh7fff)}, py: '{default: coord_type'(16'sh7fff)}};
      segments_waiting.push_back(seg);
      seg = '{px: '{default: coord_type'(16'sh8000)}, py: '{default: coord_type'(16'sh8000)}};
      segments_waiting.push_back(seg);
      seg.px = '{coord_type'(16'sh8000), coord_type'(16'sh7fff),
                 coord_type'(16'sh8000), coord_type'(16'sh7fff)};
      seg.py = '{coord_type'(16'sh7fff), coord_type'(16'sh8000),
                 coord_type'(16'sh7fff), coord_type'(16'sh8000)};
      segments_waiting.push_back(seg);
      seg.px = '{coord_type'(16'sh7fff), coord_type'(16'sh8000),
                 coord_type'(16'sh8000), coord_type'(16'sh7fff)};
      seg.py = '{coord_type'(16'sh8000), coord_type'(16'sh7fff),
                 coord_type'(16'sh7fff), coord_type'(16'sh8000)};
      segments_waiting.push_back(seg);
      // A straight line with a constant negative y checks floor on small steps.
      seg.px = '{coord_type'(0), coord_type'(1000), coord_type'(2000), coord_type'(3000)};
      seg.py = '{default: coord_type'(-1)};
      segments_waiting.push_back(seg);

      // Zero steps must behave as one step: only the two end points.
      start_phase(steps_type'(0), 1'b1, 1'b0);
      seg.px = '{coord_type'(16'sh8000), coord_type'(16'sh7fff),
                 coord_type'(16'sh8000), coord_type'(16'sh7fff)};
      seg.py = '{coord_type'(16'sh7fff), coord_type'(16'sh8000),
                 coord_type'(16'sh7fff), coord_type'(16'sh8000)};
      segments_waiting.push_back(seg);
      seg = '{px: '{default: coord_type'(16'sh8000)}, py: '{default: coord_type'(16'sh7fff)}};
      segments_waiting.push_back(seg);
      segments_waiting.push_back(random_segment());
      segments_waiting.push_back(random_segment());

      // The largest step count, with one of the zigzag shapes again.
      start_phase(steps_type'(MAX_STEPS), 1'b0, 1'b1);
      seg.px = '{coord_type'(16'sh7fff), coord_type'(16'sh8000),
                 coord_type'(16'sh8000), coord_type'(16'sh7fff)};
      seg.py = '{coord_type'(16'sh8000), coord_type'(16'sh7fff),
                 coord_type'(16'sh7fff), coord_type'(16'sh8000)};
      segments_waiting.push_back(seg);
      segments_waiting.push_back(random_segment());

      // The smallest legal step count.
      start_phase(steps_type'(1), 1'b0, 1'b0);
      segments_waiting.push_back(random_segment());
      segments_waiting.push_back(random_segment());

      // Random phases. Most use small step counts to keep the run short;
      // now and then a phase uses zero steps or the maximum.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: begin
               steps = steps_type'(0);
               phase_items = $urandom_range(10, 25);
            end
            1: begin
               steps = steps_type'(MAX_STEPS);
               phase_items = $urandom_range(2, 4);
            end
            default: begin
               steps = steps_type'($urandom_range(1, 12));
               phase_items = $urandom_range(12, 30);
            end
         endcase
         start_phase(steps, ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0));
         for (int n = 0; n < phase_items; n++) begin
            segments_waiting.push_back(random_segment());
         end
         issued += phase_items;
      end

      // Let everything drain, then allow time for any stray word to show up.
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
